// ===== src/twlk_pkg.sv =====
// Shared types and constants for the two-level page table walker.
// No dependencies; imported by every module of the walker.
package twlk_pkg;

    localparam logic [31:0] FRAME_MASK = 32'hFFFF_F000;
    localparam logic [31:0] LARGE_MASK = 32'hFFC0_0000;
    localparam logic [31:0] LARGE_OFS_MASK = 32'h003F_FFFF;
    localparam logic [31:0] PAGE_OFS_MASK = 32'h0000_0FFF;

    localparam int ENT_PRESENT_BIT = 0;
    localparam int ENT_WRITABLE_BIT = 1;
    localparam int ENT_LARGE_BIT = 7;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 104;

    typedef enum logic {
        FUNC_REQUEST  = 1'b0,
        FUNC_RESPONSE = 1'b1
    } func_t;

    typedef enum logic {
        KIND_READ  = 1'b0,
        KIND_FINAL = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NOT_PRESENT = 2'd1,
        ST_UNEXPECTED  = 2'd2
    } status_t;

    // Classified beat handed from the front to the back.
    // data is the directory entry address for a request, the entry word for a response.
    typedef struct packed {
        func_t       op;
        logic [31:0] virt_addr;
        logic [31:0] data;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] entry_word;
        logic        large_page;
        logic        writable;
        status_t     status;
        logic [31:0] phys_addr;
        logic [31:0] mem_addr;
    } result_t;

endpackage

// ===== src/two_level_page_table_walker_top.sv =====
// Top level of the two-level page table walker: front decode, command queue,
// and walk back end. Depends on twlk_pkg, twlk_front, twlk_queue, twlk_back.
//
//  Channel  Dir  Beat contents
//  s_axis   in   tuser: func; tdata: virt_addr, dir_base, mem_data
//  m_axis   out  tuser: kind; tdata: mem_addr, phys_addr, status, writable,
//                large_page, entry_word
//  cfg      in   cfg_wr_data: write_protect_on
//
// One beat per cycle in and out unless m_axis stalls or the queue fills; every input beat gives one result beat.
// Each beat is registered first in the command queue and then in the output register.
// Reset clears the queue, the output valid flag and the walk phase; write protect resets to 1.
// The output register refills in the cycle it is taken; the queue absorbs
// up to FIFO_DEPTH beats while m_axis stalls, then s_axis_tready drops.
module two_level_page_table_walker_top #(
    parameter int FIFO_DEPTH = 2
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_wr_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [31:0] virt_addr, [63:32] dir_base, [95:64] mem_data
    input  logic [twlk_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] func
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [31:0] mem_addr, [63:32] phys_addr, [65:64] status, [66] writable,
    // [67] large_page, [99:68] entry_word, [103:100] zero
    output logic [twlk_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // [0] kind
    output logic                           m_axis_tuser
);
    import twlk_pkg::*;

    queue_stat_t q_stat;
    cmd_t        push_cmd;
    cmd_t        head_cmd;
    logic        push;
    logic        pop;

    twlk_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_stat        (q_stat),
        .push          (push),
        .cmd           (push_cmd)
    );

    twlk_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    twlk_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .head_cmd      (head_cmd),
        .q_stat        (q_stat),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== src/twlk_front.sv =====
// Front end of the walker: accepts input beats, decodes them and forms the
// directory entry address of a new request. Depends on twlk_pkg.
module twlk_front (
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [twlk_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic                             s_axis_tuser,
    input  twlk_pkg::queue_stat_t            q_stat,
    output logic                             push,
    output twlk_pkg::cmd_t                   cmd
);
    import twlk_pkg::*;

    logic [31:0] virt_addr;
    logic [31:0] dir_base;
    logic [31:0] mem_data;
    logic [31:0] dir_entry_addr;

    assign virt_addr = s_axis_tdata[31:0];
    assign dir_base  = s_axis_tdata[63:32];
    assign mem_data  = s_axis_tdata[95:64];

    assign dir_entry_addr = (dir_base & FRAME_MASK) + {20'd0, virt_addr[31:22], 2'b00};

    assign s_axis_tready = !q_stat.full;
    assign push = s_axis_tvalid && !q_stat.full;

    always_comb begin
        cmd.op = func_t'(s_axis_tuser);
        cmd.virt_addr = virt_addr;
        unique case (func_t'(s_axis_tuser))
            FUNC_REQUEST:  cmd.data = dir_entry_addr;
            FUNC_RESPONSE: cmd.data = mem_data;
            default:       cmd.data = mem_data;
        endcase
    end

endmodule

// ===== src/twlk_queue.sv =====
// Short command queue between the front and the back of the walker.
// Register-array FIFO; depends on twlk_pkg for the command type.
module twlk_queue #(
    parameter int DEPTH = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  twlk_pkg::cmd_t        push_cmd,
    input  logic                  pop,
    output twlk_pkg::cmd_t        head_cmd,
    output twlk_pkg::queue_stat_t q_stat
);
    import twlk_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_stat.full  = (count_reg == FULL_CNT);
    assign q_stat.empty = (count_reg == '0);
    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && !q_stat.empty;
    assign head_cmd = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== src/twlk_back.sv =====
// Back end of the walker: holds the walk phase and saved virtual address,
// executes queued commands and registers each result. Depends on twlk_pkg.
module twlk_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_wr_data,
    input  twlk_pkg::cmd_t                 head_cmd,
    input  twlk_pkg::queue_stat_t          q_stat,
    output logic                           pop,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [twlk_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tuser
);
    import twlk_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_DIR   = 3'b010,
        PH_TABLE = 3'b100
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] va_reg, va_next;
    logic        wp_reg, wp_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;
    logic [31:0] word;
    logic        wr_bit;
    logic [31:0] table_entry_addr;

    assign pop = !q_stat.empty && (!out_valid_reg || m_axis_tready);

    assign word = head_cmd.data;
    assign wr_bit = !wp_reg || word[ENT_WRITABLE_BIT];
    assign table_entry_addr = (word & FRAME_MASK) + {20'd0, va_reg[21:12], 2'b00};

    assign wp_next = cfg_wr_en ? cfg_wr_data : wp_reg;

    always_comb begin
        phase_next = phase_reg;
        va_next = va_reg;
        out_next = '0;
        out_next.kind = KIND_FINAL;
        out_next.status = ST_UNEXPECTED;
        if (head_cmd.op == FUNC_REQUEST) begin
            phase_next = PH_DIR;
            va_next = head_cmd.virt_addr;
            out_next.kind = KIND_READ;
            out_next.status = ST_OK;
            out_next.mem_addr = word;
        end else begin
            unique case (phase_reg)
                PH_DIR: begin
                    if (!word[ENT_PRESENT_BIT]) begin
                        phase_next = PH_IDLE;
                        out_next.status = ST_NOT_PRESENT;
                    end else if (word[ENT_LARGE_BIT]) begin
                        phase_next = PH_IDLE;
                        out_next.status = ST_OK;
                        out_next.phys_addr = (word & LARGE_MASK) | (va_reg & LARGE_OFS_MASK);
                        out_next.writable = wr_bit;
                        out_next.large_page = 1'b1;
                        out_next.entry_word = word;
                    end else begin
                        phase_next = PH_TABLE;
                        out_next.kind = KIND_READ;
                        out_next.status = ST_OK;
                        out_next.mem_addr = table_entry_addr;
                    end
                end
                PH_TABLE: begin
                    phase_next = PH_IDLE;
                    if (!word[ENT_PRESENT_BIT]) begin
                        out_next.status = ST_NOT_PRESENT;
                    end else begin
                        out_next.status = ST_OK;
                        out_next.phys_addr = (word & FRAME_MASK) | (va_reg & PAGE_OFS_MASK);
                        out_next.writable = wr_bit;
                        out_next.entry_word = word;
                    end
                end
                default: begin
                    // stray response: report it and stay idle
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (pop) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            va_reg        <= '0;
            wp_reg        <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            wp_reg        <= wp_next;
            out_valid_reg <= out_valid_next;
            if (pop) begin
                phase_reg <= phase_next;
                va_reg    <= va_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tdata  = {4'd0, out_reg.entry_word, out_reg.large_page, out_reg.writable,
                            out_reg.status, out_reg.phys_addr, out_reg.mem_addr};

`ifndef SYNTHESIS
    a_final_ends_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && out_next.kind == KIND_FINAL) |=> (phase_reg == PH_IDLE))
        else $error("walk not idle after a final result");

    a_request_starts_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && head_cmd.op == FUNC_REQUEST) |=>
        (phase_reg == PH_DIR && va_reg == $past(head_cmd.virt_addr)))
        else $error("request did not start a directory read");

    a_fail_fields_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.status != ST_OK) |->
        (out_reg.kind == KIND_FINAL && out_reg.phys_addr == '0 &&
         out_reg.entry_word == '0 && !out_reg.writable && !out_reg.large_page))
        else $error("failed walk carries nonzero fields");
`endif

endmodule
